// File: rtl/hsl2rgb_pkg.sv
// Package for the HSL to RGB converter: fixed point constants, payload types,
// per-stage pipeline types and the saturation helper. No dependencies.
package hsl2rgb_pkg;

  // Number of fraction bits; ONE_FX stands for 1.0.
  localparam int unsigned FRAC_BITS = 12;

  localparam int unsigned HUE_W  = FRAC_BITS;      // one full turn wraps at ONE_FX
  localparam int unsigned VAL_W  = FRAC_BITS + 1;  // holds 0..ONE_FX
  localparam int unsigned SUM_W  = FRAC_BITS + 2;  // holds 0..2*ONE_FX
  localparam int unsigned H6_W   = HUE_W + 3;      // hue times six
  localparam int unsigned SEXT_W = 3;

  typedef logic [HUE_W-1:0]     hue_t;
  typedef logic [VAL_W-1:0]     val_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [FRAC_BITS-1:0] frac_t;

  localparam val_t ONE_FX  = val_t'(1) << FRAC_BITS;
  localparam val_t HALF_FX = val_t'(1) << (FRAC_BITS - 1);

  // Sextants of the color wheel, named by the two primaries they span.
  typedef enum logic [SEXT_W-1:0] {
    SEXT_RY = 3'd0,
    SEXT_YG = 3'd1,
    SEXT_GC = 3'd2,
    SEXT_CB = 3'd3,
    SEXT_BM = 3'd4,
    SEXT_MR = 3'd5
  } sext_e;

  typedef struct packed {
    hue_t hue;
    val_t saturation;
    val_t lightness;
  } hsl_t;

  typedef struct packed {
    val_t red;
    val_t green;
    val_t blue;
  } rgb_t;

  // After the first stage: clamped inputs, their product and the hue split.
  typedef struct packed {
    val_t  s;
    val_t  l;
    val_t  ls;
    logic [SEXT_W-1:0] sext;
    frac_t fract;
  } s1_t;

  // After the second stage: value, minimum and the black flag.
  typedef struct packed {
    val_t  v;
    val_t  m;
    logic [SEXT_W-1:0] sext;
    frac_t fract;
    logic  black;
  } s2_t;

  // After the third stage: the scaled ramp between minimum and value.
  typedef struct packed {
    val_t v;
    val_t m;
    val_t vsf;
    logic [SEXT_W-1:0] sext;
    logic black;
  } s3_t;

  function automatic val_t clamp_one(input sum_t x);
    clamp_one = (x > sum_t'(ONE_FX)) ? ONE_FX : x[VAL_W-1:0];
  endfunction

endpackage

// File: rtl/hsl2rgb_if.sv
// Valid/ready channel interfaces for HSL input pixels and RGB output pixels.
// Depends on hsl2rgb_pkg for the payload types.
interface hsl2rgb_in_if;
  logic              valid;
  logic              ready;
  hsl2rgb_pkg::hsl_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hsl2rgb_out_if;
  logic              valid;
  logic              ready;
  hsl2rgb_pkg::rgb_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/hsl_to_rgb_conversion_top.sv
// HSL to RGB pixel converter, four register stages deep.
// Throughput: one pixel per cycle while the output is not stalled; the
// stages advance independently, so a stall at the output only holds the
// stages that are occupied.
// Reset: rst_ni clears all stage valid bits asynchronously; the pipeline is
// empty and ready right after reset is released.
module hsl_to_rgb_conversion_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hsl2rgb_in_if.sink           hsl_i,
  hsl2rgb_out_if.source        rgb_o
);

  // Handshake and payload between the front stages and the ramp stage.
  logic             front_valid;
  logic             ramp_ready;
  hsl2rgb_pkg::s2_t front_data;

  // Handshake and payload between the ramp stage and the output stage.
  logic             ramp_valid;
  logic             mix_ready;
  hsl2rgb_pkg::s3_t ramp_data;

  // Stages one and two: clamp the inputs, form lightness times saturation
  // and split the hue; then derive the value and the minimum level.
  hsl2rgb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hsl_i.valid),
    .ready_o (hsl_i.ready),
    .data_i  (hsl_i.data),
    .valid_o (front_valid),
    .ready_i (ramp_ready),
    .data_o  (front_data)
  );

  // Stage three: the second multiplier, which scales the span between the
  // value and the minimum by the fractional position within the sextant.
  hsl2rgb_ramp u_ramp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .ready_o (ramp_ready),
    .data_i  (front_data),
    .valid_o (ramp_valid),
    .ready_i (mix_ready),
    .data_o  (ramp_data)
  );

  // Stage four: the output register. It picks the channel permutation for
  // the sextant and forces black when the value is zero.
  hsl2rgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ramp_valid),
    .ready_o (mix_ready),
    .data_i  (ramp_data),
    .valid_o (rgb_o.valid),
    .ready_i (rgb_o.ready),
    .data_o  (rgb_o.data)
  );

endmodule

// File: rtl/hsl2rgb_front.sv
// First two pipeline stages: input clamping, lightness-saturation product,
// hue split, then value and minimum. Depends on hsl2rgb_pkg.
module hsl2rgb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  hsl2rgb_pkg::hsl_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output hsl2rgb_pkg::s2_t  data_o
);

  logic                                  a_valid_q;
  logic                                  a_ready;
  hsl2rgb_pkg::s1_t                      a_d, a_q;
  logic                                  b_valid_q;
  logic                                  b_ready;
  hsl2rgb_pkg::s2_t                      b_d, b_q;
  logic [2*hsl2rgb_pkg::VAL_W-1:0]       prod;
  logic [hsl2rgb_pkg::H6_W-1:0]          h6;
  hsl2rgb_pkg::sum_t                     sum;
  hsl2rgb_pkg::sum_t                     two_l;
  hsl2rgb_pkg::val_t                     v;

  // Stage A: clamp, multiply, split the hue into sextant and fraction.
  always_comb begin
    a_d.s  = hsl2rgb_pkg::clamp_one(hsl2rgb_pkg::sum_t'(data_i.saturation));
    a_d.l  = hsl2rgb_pkg::clamp_one(hsl2rgb_pkg::sum_t'(data_i.lightness));
    prod   = (2 * hsl2rgb_pkg::VAL_W)'(a_d.l) * (2 * hsl2rgb_pkg::VAL_W)'(a_d.s);
    a_d.ls = prod[hsl2rgb_pkg::FRAC_BITS +: hsl2rgb_pkg::VAL_W];
    h6     = (hsl2rgb_pkg::H6_W'(data_i.hue) << 2) + (hsl2rgb_pkg::H6_W'(data_i.hue) << 1);
    a_d.sext  = h6[hsl2rgb_pkg::H6_W-1 -: hsl2rgb_pkg::SEXT_W];
    a_d.fract = h6[hsl2rgb_pkg::FRAC_BITS-1:0];
  end

  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_q <= a_d;
    end
  end

  // Stage B: value saturated to one, minimum clamped at zero.
  always_comb begin
    if (a_q.l <= hsl2rgb_pkg::HALF_FX) begin
      sum = hsl2rgb_pkg::sum_t'(a_q.l) + hsl2rgb_pkg::sum_t'(a_q.ls);
    end else begin
      sum = hsl2rgb_pkg::sum_t'(a_q.l) + hsl2rgb_pkg::sum_t'(a_q.s)
            - hsl2rgb_pkg::sum_t'(a_q.ls);
    end
    v     = hsl2rgb_pkg::clamp_one(sum);
    two_l = hsl2rgb_pkg::sum_t'(a_q.l) << 1;
    b_d.v = v;
    if (two_l > hsl2rgb_pkg::sum_t'(v)) begin
      b_d.m = hsl2rgb_pkg::clamp_one(two_l - hsl2rgb_pkg::sum_t'(v));
    end else begin
      b_d.m = '0;
    end
    b_d.sext  = a_q.sext;
    b_d.fract = a_q.fract;
    b_d.black = (v == '0);
  end

  assign b_ready = !b_valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_q;

endmodule

// File: rtl/hsl2rgb_ramp.sv
// Third pipeline stage: scales the span between value and minimum by the
// hue fraction. Depends on hsl2rgb_pkg.
module hsl2rgb_ramp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  hsl2rgb_pkg::s2_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output hsl2rgb_pkg::s3_t data_o
);

  logic                                                   valid_q;
  hsl2rgb_pkg::s3_t                                       data_d, data_q;
  hsl2rgb_pkg::val_t                                      span;
  logic [hsl2rgb_pkg::VAL_W+hsl2rgb_pkg::FRAC_BITS-1:0]   prod;

  // The minimum never exceeds the value, so the span cannot wrap.
  always_comb begin
    span        = data_i.v - data_i.m;
    prod        = (hsl2rgb_pkg::VAL_W + hsl2rgb_pkg::FRAC_BITS)'(span)
                  * (hsl2rgb_pkg::VAL_W + hsl2rgb_pkg::FRAC_BITS)'(data_i.fract);
    data_d.v    = data_i.v;
    data_d.m    = data_i.m;
    data_d.vsf  = hsl2rgb_pkg::val_t'(prod >> hsl2rgb_pkg::FRAC_BITS);
    data_d.sext = data_i.sext;
    data_d.black = data_i.black;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/hsl2rgb_mix.sv
// Last pipeline stage and output register: forms the two intermediate
// levels and routes them to red, green and blue. Depends on hsl2rgb_pkg.
module hsl2rgb_mix (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  hsl2rgb_pkg::s3_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output hsl2rgb_pkg::rgb_t data_o
);

  logic              valid_q;
  hsl2rgb_pkg::rgb_t data_d, data_q;
  hsl2rgb_pkg::val_t mid_up;
  hsl2rgb_pkg::val_t mid_dn;

  always_comb begin
    mid_up = data_i.m + data_i.vsf;
    mid_dn = data_i.v - data_i.vsf;
    case (hsl2rgb_pkg::sext_e'(data_i.sext))
      hsl2rgb_pkg::SEXT_RY: data_d = '{red: data_i.v, green: mid_up, blue: data_i.m};
      hsl2rgb_pkg::SEXT_YG: data_d = '{red: mid_dn, green: data_i.v, blue: data_i.m};
      hsl2rgb_pkg::SEXT_GC: data_d = '{red: data_i.m, green: data_i.v, blue: mid_up};
      hsl2rgb_pkg::SEXT_CB: data_d = '{red: data_i.m, green: mid_dn, blue: data_i.v};
      hsl2rgb_pkg::SEXT_BM: data_d = '{red: mid_up, green: data_i.m, blue: data_i.v};
      default:              data_d = '{red: data_i.v, green: data_i.m, blue: mid_dn};
    endcase
    if (data_i.black) begin
      data_d = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for hsl_to_rgb_conversion_top: directed and random HSL pixels,
// a bit-exact color predictor and an in-order scoreboard on the RGB channel.
// Depends on hsl2rgb_pkg, the hsl2rgb_in_if / hsl2rgb_out_if interfaces and the top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hsl2rgb_pkg::*;

  // The pipeline is four stages deep; the drain window leaves room for a few
  // stray results to show up after the last expected one.
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned RANDOM_PIXELS = 2000;
  // Number of transactions after which a side picks a new idling style.
  localparam int unsigned MODE_SPAN     = 150;

  // Idling styles: back to back, a random wait on every transaction, or
  // mostly back to back with an occasional wait.
  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_e;

  logic clk;
  logic rst_n;

  hsl2rgb_in_if  hsl_ch ();
  hsl2rgb_out_if rgb_ch ();

  hsl_to_rgb_conversion_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .hsl_i  (hsl_ch),
    .rgb_o  (rgb_ch)
  );

  // Pixels waiting to be driven and colors waiting to come out, oldest first.
  hsl_t pixel_q[$];
  rgb_t rgb_expected[$];

  // Handshake flags captured at the rising edge and used by the drivers at the
  // following falling edge.
  logic px_fire;
  logic rgb_fire;

  int unsigned px_gap;
  int unsigned rgb_stall;
  int unsigned px_done_count;
  int unsigned rgb_done_count;
  idle_mode_e  px_mode;
  idle_mode_e  rgb_mode;

  int unsigned px_total;
  int unsigned px_sent;
  int unsigned rgb_checked;
  int unsigned mismatches;
  int unsigned dark_count;
  int unsigned over_one_count;
  int unsigned sext_hits [6];

  // ---------------------------------------------------------------------------
  // Color predictor. Saturation and lightness are saturated to one, the value
  // v is built from them and saturated again, and the hue times six splits into
  // a sextant and a fraction that ramps between the minimum m and v.
  // ---------------------------------------------------------------------------
  function automatic rgb_t hsl_to_rgb_expected(input hsl_t px, output sext_e part,
                                               output bit dark);
    int unsigned one_v, sat, lit, ls, v, m, h6, fract, vsf;
    val_t        hi, lo, up, dn;
    rgb_t        rgb;
    one_v = 1 << FRAC_BITS;
    sat   = px.saturation;
    lit   = px.lightness;
    if (sat > one_v) sat = one_v;
    if (lit > one_v) lit = one_v;
    ls = (lit * sat) >> FRAC_BITS;
    v  = (lit <= one_v / 2) ? lit + ls : lit + sat - ls;
    if (v > one_v) v = one_v;
    // The hue field is exactly one turn wide, so it needs no wrapping here.
    h6    = px.hue * 6;
    part  = sext_e'(h6 >> FRAC_BITS);
    fract = h6 & (one_v - 1);
    dark  = (v == 0);
    rgb   = '0;
    if (dark) return rgb;
    m   = (2 * lit > v) ? 2 * lit - v : 0;
    vsf = ((v - m) * fract) >> FRAC_BITS;
    hi  = val_t'(v);
    lo  = val_t'(m);
    up  = val_t'(m + vsf);
    dn  = val_t'(v - vsf);
    case (part)
      SEXT_RY: begin rgb.red = hi; rgb.green = up; rgb.blue = lo; end
      SEXT_YG: begin rgb.red = dn; rgb.green = hi; rgb.blue = lo; end
      SEXT_GC: begin rgb.red = lo; rgb.green = hi; rgb.blue = up; end
      SEXT_CB: begin rgb.red = lo; rgb.green = dn; rgb.blue = hi; end
      SEXT_BM: begin rgb.red = up; rgb.green = lo; rgb.blue = hi; end
      default: begin rgb.red = hi; rgb.green = lo; rgb.blue = dn; end
    endcase
    return rgb;
  endfunction

  function automatic int unsigned idle_cycles(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 19);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
  endfunction

  // Hue draws favor the sextant borders and both ends of the wheel.
  function automatic hue_t rand_hue();
    int wheel_pt;
    case ($urandom_range(0, 7))
      0: begin
        wheel_pt = int'($urandom_range(0, 5)) * int'(ONE_FX) / 6
                   + int'($urandom_range(0, 3)) - 1;
        return hue_t'(wheel_pt);
      end
      1:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return hue_t'($urandom_range(0, 4095));
    endcase
  endfunction

  // Saturation and lightness draws cover zero, one, the half point, values
  // just below one and the whole range above one that the 13-bit field allows.
  function automatic val_t rand_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ONE_FX;
      2:       return val_t'($urandom_range(ONE_FX + 1, 8191));
      3:       return val_t'($urandom_range(0, 15));
      4:       return val_t'($urandom_range(HALF_FX - 8, HALF_FX + 8));
      5:       return val_t'($urandom_range(ONE_FX - 16, ONE_FX));
      default: return val_t'($urandom_range(0, ONE_FX));
    endcase
  endfunction

  task automatic queue_pixel(input hue_t hue, input val_t sat, input val_t lit);
    hsl_t px;
    px.hue        = hue;
    px.saturation = sat;
    px.lightness  = lit;
    if (sat > ONE_FX || lit > ONE_FX) over_one_count++;
    pixel_q.push_back(px);
  endtask

  task automatic report_mismatch(input string why, input rgb_t want, input rgb_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d", $time, why,
               want.red, want.green, want.blue, got.red, got.green, got.blue);
  endtask

  // ---------------------------------------------------------------------------
  // Clock and the initial values of every input of the block. Reset starts
  // asserted and is released by the stimulus process.
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk          = 1'b0;
    rst_n        = 1'b0;
    hsl_ch.valid = 1'b0;
    hsl_ch.data  = '0;
    rgb_ch.ready = 1'b0;
    px_fire      = 1'b0;
    rgb_fire     = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard. Everything is sampled at the rising edge, where
  // the inputs (driven at the falling edge) are stable. A completed output
  // transaction is checked against the oldest expected color; a completed
  // input transaction has its color predicted and queued.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    rgb_t  want;
    sext_e part;
    bit    dark;
    if (!rst_n) begin
      px_fire  <= 1'b0;
      rgb_fire <= 1'b0;
    end else begin
      px_fire  <= hsl_ch.valid && hsl_ch.ready;
      rgb_fire <= rgb_ch.valid && rgb_ch.ready;
      if (rgb_ch.valid && rgb_ch.ready) begin
        if (rgb_expected.size() == 0) begin
          report_mismatch("color with no pixel pending", '0, rgb_ch.data);
        end else begin
          want = rgb_expected.pop_front();
          if (rgb_ch.data.red !== want.red || rgb_ch.data.green !== want.green ||
              rgb_ch.data.blue !== want.blue)
            report_mismatch("color mismatch", want, rgb_ch.data);
          rgb_checked++;
        end
      end
      if (hsl_ch.valid && hsl_ch.ready) begin
        rgb_expected.push_back(hsl_to_rgb_expected(hsl_ch.data, part, dark));
        px_sent++;
        if (dark) dark_count++;
        else sext_hits[part]++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel driver. At each falling edge it retires the pixel whose transaction
  // completed at the previous rising edge, draws the idle gap before the next
  // one and presents the next queued pixel once the gap has run out. The next
  // valid and payload are worked out first and assigned once, so valid stays
  // high without a glitch when pixels go back to back.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : pixel_driver
    logic next_valid;
    hsl_t next_px;
    next_valid = hsl_ch.valid;
    next_px    = hsl_ch.data;
    if (rst_n) begin
      if (px_fire) begin
        next_valid = 1'b0;
        px_gap     = idle_cycles(px_mode);
        px_done_count++;
        if (px_done_count % MODE_SPAN == 0) px_mode = idle_mode_e'($urandom_range(0, 2));
      end
      if (!next_valid) begin
        if (px_gap > 0) begin
          px_gap--;
        end else if (pixel_q.size() > 0) begin
          next_px    = pixel_q.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    hsl_ch.valid <= next_valid;
    hsl_ch.data  <= next_px;
  end

  // ---------------------------------------------------------------------------
  // Color sink. After each completed output transaction it draws a stall and
  // holds ready low while the stall counts down; otherwise ready waits high.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : rgb_sink
    if (rgb_fire) begin
      rgb_stall = idle_cycles(rgb_mode);
      rgb_done_count++;
      if (rgb_done_count % MODE_SPAN == 0) rgb_mode = idle_mode_e'($urandom_range(0, 2));
    end
    if (rgb_stall > 0) begin
      rgb_stall--;
      rgb_ch.ready <= 1'b0;
    end else begin
      rgb_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test. The directed pixels come first: black, white,
  // gray, full saturation across every sextant border, inputs above one, a
  // minimum that sits near zero and the largest value the rounding allows.
  // The random pixels follow. Once every pixel has gone in and every color has
  // come out, a short drain catches stray results before the verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    px_gap         = 0;
    rgb_stall      = 0;
    px_done_count  = 0;
    rgb_done_count = 0;
    px_mode        = IDLE_FULL;
    rgb_mode       = IDLE_NONE;
    px_sent        = 0;
    rgb_checked    = 0;
    mismatches     = 0;
    dark_count     = 0;
    over_one_count = 0;
    foreach (sext_hits[k]) sext_hits[k] = 0;

    // Black from zero lightness, with and without saturation.
    queue_pixel(12'd0, 13'd0, 13'd0);
    queue_pixel(12'd1000, ONE_FX, 13'd0);
    // White and mid gray.
    queue_pixel(12'd0, 13'd0, ONE_FX);
    queue_pixel(12'd4095, ONE_FX, ONE_FX);
    queue_pixel(12'd1234, 13'd0, HALF_FX);
    // Fully saturated primaries and both sides of every sextant border.
    queue_pixel(12'd0, ONE_FX, HALF_FX);
    queue_pixel(12'd682, ONE_FX, HALF_FX);
    queue_pixel(12'd683, ONE_FX, HALF_FX);
    queue_pixel(12'd1365, ONE_FX, HALF_FX);
    queue_pixel(12'd1366, ONE_FX, HALF_FX);
    queue_pixel(12'd2047, ONE_FX, HALF_FX);
    queue_pixel(12'd2048, ONE_FX, HALF_FX);
    queue_pixel(12'd2730, ONE_FX, HALF_FX);
    queue_pixel(12'd2731, ONE_FX, HALF_FX);
    queue_pixel(12'd3413, ONE_FX, HALF_FX);
    queue_pixel(12'd3414, ONE_FX, HALF_FX);
    queue_pixel(12'd4095, ONE_FX, HALF_FX);
    // Saturation and lightness above one are saturated before use.
    queue_pixel(12'd2222, 13'd8191, 13'd8191);
    queue_pixel(12'd4095, ONE_FX + 13'd1, ONE_FX + 13'd1);
    queue_pixel(12'd3000, 13'd8191, 13'd1000);
    // Minimum close to zero just above half lightness, and near-one rounding.
    queue_pixel(12'd1500, ONE_FX, HALF_FX + 13'd1);
    queue_pixel(12'd500, ONE_FX - 13'd1, HALF_FX - 13'd1);
    queue_pixel(12'd3800, ONE_FX - 13'd1, ONE_FX - 13'd1);
    // Smallest nonzero inputs and a barely saturated bright pixel.
    queue_pixel(12'd1, 13'd1, 13'd1);
    queue_pixel(12'd2500, 13'd1, ONE_FX - 13'd1);

    for (int i = 0; i < RANDOM_PIXELS; i++) queue_pixel(rand_hue(), rand_level(), rand_level());
    px_total = pixel_q.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (px_sent == px_total);
    while (rgb_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d black, %0d with an input above one), %0d colors checked.",
             px_sent, dark_count, over_one_count, rgb_checked);
    $display("Colored pixels per sextant RY/YG/GC/CB/BM/MR: %0d/%0d/%0d/%0d/%0d/%0d, %0d mismatches.",
             sext_hits[0], sext_hits[1], sext_hits[2], sext_hits[3], sext_hits[4], sext_hits[5],
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this time.
  initial begin : watchdog
    #10ms;
    $display("Timeout with %0d of %0d pixels sent and %0d colors outstanding.",
             px_sent, px_total, rgb_expected.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: hsl_to_rgb_conversion_top.f
rtl/hsl2rgb_pkg.sv
rtl/hsl2rgb_if.sv
rtl/hsl2rgb_front.sv
rtl/hsl2rgb_ramp.sv
rtl/hsl2rgb_mix.sv
rtl/hsl_to_rgb_conversion_top.sv
tb/tb_top.sv
